### sv/vtpy_pkg.sv
package vtpy_pkg;

    localparam int GUARD_BITS     = 8;
    localparam int ATAN_ENTRIES   = 24;
    localparam int ANGLE_W        = 17;
    localparam int BAM_W          = 32;
    localparam int GAIN_W         = 18;
    localparam logic [GAIN_W-1:0] CORDIC_GAIN_Q16 = 18'd107923;
    localparam logic [BAM_W-1:0]  BAM_90  = 32'h4000_0000;
    localparam logic [BAM_W-1:0]  BAM_180 = 32'h8000_0000;
    localparam logic [BAM_W-1:0]  BAM_270 = 32'hC000_0000;
    localparam int FULL_TURN_DEGREES = 360;

    typedef logic [BAM_W-1:0] bam_t;

    localparam bam_t ATAN_BAM [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // flags that ride along with every item
    typedef struct packed {
        logic special;   // x and y both zero
        logic z_pos;     // z greater than zero
    } item_flags_t;

endpackage

### sv/vector_to_pitch_yaw.sv
// Direction vector to pitch and yaw, fully pipelined CORDIC.
// Stages: two prep stages, one register per micro-rotation in each of the
// two vectoring passes, two conversion stages. Throughput: one transfer per
// cycle; a stall on the output freezes the whole pipeline. Reset (aresetn
// low, synchronous) clears all valid bits; data registers are not reset.
module vector_to_pitch_yaw
    import vtpy_pkg::*;
#(
    parameter int COMPONENT_WIDTH     = 24,
    parameter int CORDIC_STAGES       = 18,
    parameter int ANGLE_FRACTION_BITS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // dir_x, dir_y, dir_z (lowest first), zero padded to whole bytes
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // pitch_angle, yaw_angle (lowest first), zero padded
    output logic [((2*ANGLE_W+7)/8)*8-1:0] m_tdata
);

    localparam int CW  = COMPONENT_WIDTH;
    // guard bits plus headroom for CORDIC gain growth in both passes
    localparam int W   = CW + 12;
    localparam int N   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int S1W = W + 2;
    localparam int S2W = BAM_W + 2;
    localparam int MDW = ((2*ANGLE_W+7)/8)*8;

    // whole pipeline advances together unless the output is held
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                 p1_valid [0:N];
    logic signed [W-1:0]  p1_x [0:N];
    logic signed [W-1:0]  p1_y [0:N];
    bam_t                 p1_ang [0:N];
    logic [S1W-1:0]       p1_side [0:N];

    logic                 p2_valid [0:N];
    logic signed [W-1:0]  p2_x [0:N];
    logic signed [W-1:0]  p2_y [0:N];
    bam_t                 p2_ang [0:N];
    logic [S2W-1:0]       p2_side [0:N];

    logic signed [W-1:0]  prep_zs;
    item_flags_t          prep_flags, end_flags;
    logic [ANGLE_W-1:0]   pitch_angle, yaw_angle;

    vtpy_prep #(.CW(CW), .W(W)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .dir_x     (s_tdata[CW-1:0]),
        .dir_y     (s_tdata[2*CW-1:CW]),
        .dir_z     (s_tdata[3*CW-1:2*CW]),
        .out_valid (p1_valid[0]),
        .x_out     (p1_x[0]),
        .y_out     (p1_y[0]),
        .zs_out    (prep_zs),
        .ang_out   (p1_ang[0]),
        .flags_out (prep_flags)
    );

    assign p1_side[0] = {prep_zs, prep_flags};

    // first pass: yaw and gain-scaled horizontal magnitude
    for (genvar i = 0; i < N; i++) begin : g_pass1
        vtpy_cordic_stage #(.W(W), .SHIFT(i), .SBW(S1W)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (p1_valid[i]),
            .x_in      (p1_x[i]),
            .y_in      (p1_y[i]),
            .ang_in    (p1_ang[i]),
            .side_in   (p1_side[i]),
            .out_valid (p1_valid[i+1]),
            .x_out     (p1_x[i+1]),
            .y_out     (p1_y[i+1]),
            .ang_out   (p1_ang[i+1]),
            .side_out  (p1_side[i+1])
        );
    end

    // second pass starts from (magnitude, scaled -z); carry yaw along
    assign p2_valid[0] = p1_valid[N];
    assign p2_x[0]     = p1_x[N];
    assign p2_y[0]     = $signed(p1_side[N][S1W-1:2]);
    assign p2_ang[0]   = '0;
    assign p2_side[0]  = {p1_ang[N], p1_side[N][1:0]};

    for (genvar i = 0; i < N; i++) begin : g_pass2
        vtpy_cordic_stage #(.W(W), .SHIFT(i), .SBW(S2W)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (p2_valid[i]),
            .x_in      (p2_x[i]),
            .y_in      (p2_y[i]),
            .ang_in    (p2_ang[i]),
            .side_in   (p2_side[i]),
            .out_valid (p2_valid[i+1]),
            .x_out     (p2_x[i+1]),
            .y_out     (p2_y[i+1]),
            .ang_out   (p2_ang[i+1]),
            .side_out  (p2_side[i+1])
        );
    end

    assign end_flags = p2_side[N][1:0];

    vtpy_bam_conv #(.AFB(ANGLE_FRACTION_BITS)) u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (p2_valid[N]),
        .pitch_bam   (p2_ang[N]),
        .yaw_bam     (p2_side[N][S2W-1:2]),
        .flags       (end_flags),
        .out_valid   (m_tvalid),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

    assign m_tdata = MDW'({yaw_angle, pitch_angle});

endmodule

### sv/vtpy_prep.sv
module vtpy_prep
    import vtpy_pkg::*;
#(
    parameter int CW = 24,
    parameter int W  = CW + 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [CW-1:0] dir_x,
    input  logic signed [CW-1:0] dir_y,
    input  logic signed [CW-1:0] dir_z,
    output logic                out_valid,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output logic signed [W-1:0] zs_out,
    output bam_t                ang_out,
    output item_flags_t         flags_out
);

    localparam int PW = CW + GAIN_W;
    localparam int NW = PW + GUARD_BITS + 1;

    logic                valid_a_reg;
    logic signed [W-1:0] x_a_reg, y_a_reg;
    bam_t                ang_a_reg;
    logic signed [PW-1:0] prod_a_reg;
    item_flags_t         flags_a_reg;

    logic signed [W-1:0] x_ext, y_ext, x_a_next, y_a_next;
    logic signed [PW-1:0] prod_a_next;
    logic signed [NW-1:0] zs_wide;
    logic signed [W-1:0] zs_next;

    always_comb begin
        x_ext = W'(dir_x) <<< GUARD_BITS;
        y_ext = W'(dir_y) <<< GUARD_BITS;
        if (dir_x < 0) begin
            x_a_next = -x_ext;
            y_a_next = -y_ext;
        end else begin
            x_a_next = x_ext;
            y_a_next = y_ext;
        end
        prod_a_next = PW'(dir_z) * $signed({1'b0, CORDIC_GAIN_Q16[GAIN_W-2:0]});
        zs_wide = -(NW'(prod_a_reg) <<< GUARD_BITS) + NW'(32768);
        zs_next = W'(zs_wide >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            out_valid   <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            out_valid   <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_a_reg           <= x_a_next;
            y_a_reg           <= y_a_next;
            ang_a_reg         <= (dir_x < 0) ? BAM_180 : '0;
            prod_a_reg        <= prod_a_next;
            flags_a_reg.special <= (dir_x == '0) && (dir_y == '0);
            flags_a_reg.z_pos <= (dir_z > 0);
            x_out             <= x_a_reg;
            y_out             <= y_a_reg;
            ang_out           <= ang_a_reg;
            zs_out            <= zs_next;
            flags_out         <= flags_a_reg;
        end
    end

endmodule

### sv/vtpy_cordic_stage.sv
module vtpy_cordic_stage
    import vtpy_pkg::*;
#(
    parameter int W     = 36,
    parameter int SHIFT = 0,
    parameter int SBW   = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  bam_t                ang_in,
    input  logic [SBW-1:0]      side_in,
    output logic                out_valid,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output bam_t                ang_out,
    output logic [SBW-1:0]      side_out
);

    logic signed [W-1:0] xs, ys;

    assign xs = x_in >>> SHIFT;
    assign ys = y_in >>> SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    // rotate toward y = 0
    always_ff @(posedge aclk) begin
        if (en) begin
            side_out <= side_in;
            if (!y_in[W-1]) begin
                x_out   <= x_in + ys;
                y_out   <= y_in - xs;
                ang_out <= ang_in + ATAN_BAM[SHIFT];
            end else begin
                x_out   <= x_in - ys;
                y_out   <= y_in + xs;
                ang_out <= ang_in - ATAN_BAM[SHIFT];
            end
        end
    end

endmodule

### sv/vtpy_bam_conv.sv
module vtpy_bam_conv
    import vtpy_pkg::*;
#(
    parameter int AFB = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  bam_t               pitch_bam,
    input  bam_t               yaw_bam,
    input  item_flags_t        flags,
    output logic               out_valid,
    output logic [ANGLE_W-1:0] pitch_angle,
    output logic [ANGLE_W-1:0] yaw_angle
);

    localparam int FW = 9 + AFB;
    localparam int MW = BAM_W + FW;
    localparam logic [FW-1:0] FULL = FW'(FULL_TURN_DEGREES) << AFB;
    localparam logic [MW-1:0] HALF = MW'(64'h8000_0000);

    logic             valid_m_reg;
    logic [MW-1:0]    pitch_m_reg, yaw_m_reg;
    bam_t             pitch_sel, yaw_sel;
    logic [FW:0]      pitch_r, yaw_r;

    always_comb begin
        pitch_sel = pitch_bam;
        yaw_sel   = yaw_bam;
        if (flags.special) begin
            yaw_sel   = '0;
            pitch_sel = flags.z_pos ? BAM_270 : BAM_90;
        end
        pitch_r = (FW+1)'((pitch_m_reg + HALF) >> BAM_W);
        yaw_r   = (FW+1)'((yaw_m_reg + HALF) >> BAM_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_m_reg <= 1'b0;
            out_valid   <= 1'b0;
        end else if (en) begin
            valid_m_reg <= in_valid;
            out_valid   <= valid_m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pitch_m_reg <= MW'(pitch_sel) * MW'(FULL);
            yaw_m_reg   <= MW'(yaw_sel) * MW'(FULL);
            // wrap a full turn to zero
            pitch_angle <= (pitch_r >= (FW+1)'(FULL)) ? '0 : ANGLE_W'(pitch_r);
            yaw_angle   <= (yaw_r >= (FW+1)'(FULL)) ? '0 : ANGLE_W'(yaw_r);
        end
    end

endmodule
